// File: src/bsq_pkg.sv
// package: shared constants, action codes and control types for the priority queue
`default_nettype none
package bsq_pkg;

	localparam int ACTION_W       = 2;
	localparam int PRIO_FIELD_W   = 8;
	localparam int HANDLE_FIELD_W = 32;
	localparam int RANK_W         = 5;
	localparam int COUNT_FIELD_W  = 5;

	localparam int CAPACITY_DEF      = 16;
	localparam int PRIORITY_BITS_DEF = 8;
	localparam int HANDLE_BITS_DEF   = 32;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RANK   = 2'd2;

	typedef struct packed {
		logic ins;
		logic pop;
	} bsq_ctrl_t;

endpackage
`default_nettype wire

// File: src/bsq_if.sv
// interfaces: request and response channels of the priority queue
`default_nettype none
interface bsq_req_if;
	logic                                valid;
	logic                                ready;
	logic [bsq_pkg::ACTION_W-1:0]        action;
	logic [bsq_pkg::PRIO_FIELD_W-1:0]    priority_req;
	logic [bsq_pkg::HANDLE_FIELD_W-1:0]  message_handle;
	logic [bsq_pkg::RANK_W-1:0]          rank;

	modport source (output valid, action, priority_req, message_handle, rank, input ready);
	modport sink (input valid, action, priority_req, message_handle, rank, output ready);
endinterface

interface bsq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                ok;
	logic [bsq_pkg::HANDLE_FIELD_W-1:0]  message_out;
	logic [bsq_pkg::PRIO_FIELD_W-1:0]    priority_out;
	logic [bsq_pkg::COUNT_FIELD_W-1:0]   count_out;

	modport source (output valid, ok, message_out, priority_out, count_out, input ready);
	modport sink (input valid, ok, message_out, priority_out, count_out, output ready);
endinterface
`default_nettype wire

// File: src/bsq_cell.sv
// cell: one queue slot, shifts towards the tail on insert and towards the head on pop
`default_nettype none
module bsq_cell #(
	parameter int PRIORITY_BITS = bsq_pkg::PRIORITY_BITS_DEF,
	parameter int HANDLE_BITS   = bsq_pkg::HANDLE_BITS_DEF
) (
	input  wire                      clk,
	input  wire bsq_pkg::bsq_ctrl_t  ctrl,
	input  wire                      occupied,
	input  wire  [PRIORITY_BITS-1:0] new_prio,
	input  wire  [HANDLE_BITS-1:0]   new_handle,
	input  wire                      left_greater,
	input  wire  [PRIORITY_BITS-1:0] left_prio,
	input  wire  [HANDLE_BITS-1:0]   left_handle,
	input  wire  [PRIORITY_BITS-1:0] right_prio,
	input  wire  [HANDLE_BITS-1:0]   right_handle,
	output logic [PRIORITY_BITS-1:0] prio,
	output logic [HANDLE_BITS-1:0]   handle,
	output logic                     greater
);

	logic [PRIORITY_BITS-1:0] prio_q;
	logic [HANDLE_BITS-1:0]   handle_q;

	assign greater = occupied && (prio_q > new_prio);
	assign prio    = prio_q;
	assign handle  = handle_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!left_greater) begin
				prio_q   <= left_prio;
				handle_q <= left_handle;
			end else if (!greater) begin
				prio_q   <= new_prio;
				handle_q <= new_handle;
			end
		end else if (ctrl.pop) begin
			prio_q   <= right_prio;
			handle_q <= right_handle;
		end
	end

endmodule
`default_nettype wire

// File: src/bounded_sorted_priority_queue.sv
// top level: bounded priority queue built from a row of sorted cells
// the response word is registered and appears in the cycle after its request word is accepted
// throughput: one word per cycle unless stalled, every cell compares and shifts in the same cycle
// while a response waits in the output register the request side stalls
// reset: asynchronous, clears the entry count and the response valid; slot contents are not cleared
`default_nettype none
module bounded_sorted_priority_queue #(
	parameter int CAPACITY      = bsq_pkg::CAPACITY_DEF,
	parameter int PRIORITY_BITS = bsq_pkg::PRIORITY_BITS_DEF,
	parameter int HANDLE_BITS   = bsq_pkg::HANDLE_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	bsq_req_if.sink    req,
	bsq_rsp_if.source  rsp
);

	localparam int CW       = $clog2(CAPACITY + 1);
	localparam int PFW      = bsq_pkg::PRIO_FIELD_W;
	localparam int HFW      = bsq_pkg::HANDLE_FIELD_W;
	localparam int RW       = bsq_pkg::RANK_W;
	localparam int CFW      = bsq_pkg::COUNT_FIELD_W;
	localparam int RANK_MAX = (1 << RW) - 1;
	localparam int RD_CELLS = (CAPACITY < RANK_MAX) ? CAPACITY : RANK_MAX;

	logic [CW-1:0]            count_q;
	logic                     valid_q;
	logic                     ok_q;
	logic [HFW-1:0]           msg_q;
	logic [PFW-1:0]           prio_q;
	logic [CFW-1:0]           cnt_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     ins_ok;
	logic                     pop_ok;
	logic                     rank_ok;
	bsq_pkg::bsq_ctrl_t       ctrl;
	logic [CW-1:0]            count_nxt;
	logic [CW+CFW-1:0]        count_ext;
	logic [CW+RW-1:0]         rank_ext;
	logic [PRIORITY_BITS+PFW-1:0] prio_in_ext;
	logic [HANDLE_BITS+HFW-1:0]   handle_in_ext;
	logic [PRIORITY_BITS-1:0] new_prio;
	logic [HANDLE_BITS-1:0]   new_handle;
	logic [PRIORITY_BITS-1:0] rank_prio;
	logic [PRIORITY_BITS+PFW-1:0] prio_out_ext;
	logic [HANDLE_BITS+HFW-1:0]   handle_out_ext;

	logic [PRIORITY_BITS-1:0] cell_prio    [CAPACITY];
	logic [HANDLE_BITS-1:0]   cell_handle  [CAPACITY];
	logic                     cell_greater [CAPACITY];
	logic [PRIORITY_BITS-1:0] rd_prio      [RD_CELLS];

	assign req.ready = !valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign prio_in_ext   = {{PRIORITY_BITS{1'b0}}, req.priority_req};
	assign handle_in_ext = {{HANDLE_BITS{1'b0}}, req.message_handle};
	assign new_prio      = prio_in_ext[PRIORITY_BITS-1:0];
	assign new_handle    = handle_in_ext[HANDLE_BITS-1:0];

	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign rank_ext = {{CW{1'b0}}, req.rank};
	assign rank_ok  = (req.rank != '0) && (rank_ext <= {{RW{1'b0}}, count_q});
	assign ins_ok   = accept && (req.action == bsq_pkg::ACT_INSERT) && !full;
	assign pop_ok   = accept && (req.action == bsq_pkg::ACT_POP) && !empty;
	assign ctrl.ins = ins_ok;
	assign ctrl.pop = pop_ok;

	always_comb begin
		count_nxt = count_q;
		if (ins_ok) begin
			count_nxt = count_q + CW'(1);
		end else if (pop_ok) begin
			count_nxt = count_q - CW'(1);
		end
	end

	assign count_ext = {{CFW{1'b0}}, count_nxt};

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic                     l_greater;
			logic [PRIORITY_BITS-1:0] l_prio;
			logic [HANDLE_BITS-1:0]   l_handle;
			logic [PRIORITY_BITS-1:0] r_prio;
			logic [HANDLE_BITS-1:0]   r_handle;

			if (gi == 0) begin : g_head
				assign l_greater = 1'b1;
				assign l_prio    = new_prio;
				assign l_handle  = new_handle;
			end else begin : g_body
				assign l_greater = cell_greater[gi-1];
				assign l_prio    = cell_prio[gi-1];
				assign l_handle  = cell_handle[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_tail
				assign r_prio   = cell_prio[gi];
				assign r_handle = cell_handle[gi];
			end else begin : g_mid
				assign r_prio   = cell_prio[gi+1];
				assign r_handle = cell_handle[gi+1];
			end

			bsq_cell #(
				.PRIORITY_BITS (PRIORITY_BITS),
				.HANDLE_BITS   (HANDLE_BITS)
			) u_cell (
				.clk          (clk),
				.ctrl         (ctrl),
				.occupied     (count_q > CW'(gi)),
				.new_prio     (new_prio),
				.new_handle   (new_handle),
				.left_greater (l_greater),
				.left_prio    (l_prio),
				.left_handle  (l_handle),
				.right_prio   (r_prio),
				.right_handle (r_handle),
				.prio         (cell_prio[gi]),
				.handle       (cell_handle[gi]),
				.greater      (cell_greater[gi])
			);
		end

		for (gi = 0; gi < RD_CELLS; gi++) begin : g_rd
			assign rd_prio[gi] = (rank_ext == (CW+RW)'(gi + 1)) ? cell_prio[gi] : '0;
		end
	endgenerate

	always_comb begin
		rank_prio = '0;
		for (int i = 0; i < RD_CELLS; i++) begin
			rank_prio = rank_prio | rd_prio[i];
		end
	end

	assign prio_out_ext   = {{PFW{1'b0}}, rank_prio};
	assign handle_out_ext = {{HFW{1'b0}}, cell_handle[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q   <= 1'b0;
			msg_q  <= '0;
			prio_q <= '0;
			cnt_q  <= count_ext[CFW-1:0];
			case (req.action)
				bsq_pkg::ACT_INSERT: begin
					ok_q <= !full;
				end
				bsq_pkg::ACT_POP: begin
					ok_q <= !empty;
					if (!empty) begin
						msg_q <= handle_out_ext[HFW-1:0];
					end
				end
				bsq_pkg::ACT_RANK: begin
					ok_q <= rank_ok;
					if (rank_ok) begin
						prio_q <= prio_out_ext[PFW-1:0];
					end
				end
				default: begin
					ok_q <= 1'b0;
				end
			endcase
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.ok           = ok_q;
	assign rsp.message_out  = msg_q;
	assign rsp.priority_out = prio_q;
	assign rsp.count_out    = cnt_q;

endmodule
`default_nettype wire

// File: src/bsq_checker.sv
// checker: port level properties of the priority queue, bound to the top level
`default_nettype none
module bsq_checker #(
	parameter int CAPACITY = bsq_pkg::CAPACITY_DEF
) (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                req_valid,
	input wire                                req_ready,
	input wire                                rsp_valid,
	input wire                                rsp_ready,
	input wire                                rsp_ok,
	input wire [bsq_pkg::HANDLE_FIELD_W-1:0]  rsp_message_out,
	input wire [bsq_pkg::PRIO_FIELD_W-1:0]    rsp_priority_out,
	input wire [bsq_pkg::COUNT_FIELD_W-1:0]   rsp_count_out
);

	// every accepted word yields a response word in the next cycle
	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> rsp_valid)
		else $error("accepted request gave no response");

	// an empty output stage never blocks the request side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with no pending response");

	// a failed action returns no data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ok) |-> (rsp_message_out == '0 && rsp_priority_out == '0))
		else $error("failed action returned data");

	// handle and priority are never both returned
	a_one_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_message_out == '0 || rsp_priority_out == '0))
		else $error("handle and priority returned together");

	// the fill level never passes capacity, checked for a capacity up to 31
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CAPACITY > 31 || 32'(rsp_count_out) <= CAPACITY))
		else $error("count beyond capacity");

endmodule

bind bounded_sorted_priority_queue bsq_checker #(
	.CAPACITY (CAPACITY)
) u_bsq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_ok           (rsp.ok),
	.rsp_message_out  (rsp.message_out),
	.rsp_priority_out (rsp.priority_out),
	.rsp_count_out    (rsp.count_out)
);
`default_nettype wire

// File: tb/sv/bounded_sorted_priority_queue_tb.sv
// testbench: request/response checking of the bounded sorted priority queue against a queue model
`default_nettype none
module bounded_sorted_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH = bsq_pkg::CAPACITY_DEF;
	localparam logic [bsq_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic                               ok;
		logic [bsq_pkg::HANDLE_FIELD_W-1:0] message_out;
		logic [bsq_pkg::PRIO_FIELD_W-1:0]   priority_out;
		logic [bsq_pkg::COUNT_FIELD_W-1:0]  count_out;
	} rsp_word_t;

	typedef enum int {SPREAD_WIDE, SPREAD_NARROW, SPREAD_EDGES} prio_spread_t;

	logic clk;
	logic arst_n;

	bsq_req_if req_ch ();
	bsq_rsp_if rsp_ch ();

	bounded_sorted_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// queue model state
	logic [bsq_pkg::PRIO_FIELD_W-1:0]   model_prio[QUEUE_DEPTH];
	logic [bsq_pkg::HANDLE_FIELD_W-1:0] model_handle[QUEUE_DEPTH];
	int                                 model_count;

	rsp_word_t expected_rsp[$];

	bit idle_allowed;
	bit src_gaps;
	bit sink_stalls;
	int errors;
	int words_sent;
	int words_checked;
	int refused_inserts;
	int empty_pops;
	int bad_ranks;
	int peak_count;
	longint cycle_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("bounded_sorted_priority_queue verification failed");
			$finish;
		end
	end

	function automatic rsp_word_t queue_model_step(input logic [bsq_pkg::ACTION_W-1:0] act,
			input logic [bsq_pkg::PRIO_FIELD_W-1:0] prio,
			input logic [bsq_pkg::HANDLE_FIELD_W-1:0] handle,
			input logic [bsq_pkg::RANK_W-1:0] rank);
		rsp_word_t res;
		int pos;
		res = '0;
		case (act)
			bsq_pkg::ACT_INSERT: begin
				if (model_count >= QUEUE_DEPTH) begin
					refused_inserts++;
				end else begin
					pos = 0;
					while (pos < model_count && model_prio[pos] > prio)
						pos++;
					for (int k = model_count; k > pos; k--) begin
						model_prio[k]   = model_prio[k-1];
						model_handle[k] = model_handle[k-1];
					end
					model_prio[pos]   = prio;
					model_handle[pos] = handle;
					model_count++;
					res.ok = 1'b1;
				end
			end
			bsq_pkg::ACT_POP: begin
				if (model_count == 0) begin
					empty_pops++;
				end else begin
					res.message_out = model_handle[0];
					for (int k = 1; k < model_count; k++) begin
						model_prio[k-1]   = model_prio[k];
						model_handle[k-1] = model_handle[k];
					end
					model_count--;
					res.ok = 1'b1;
				end
			end
			bsq_pkg::ACT_RANK: begin
				if (rank == 0 || rank > model_count) begin
					bad_ranks++;
				end else begin
					res.priority_out = model_prio[rank-1];
					res.ok = 1'b1;
				end
			end
			default: ;
		endcase
		if (model_count > peak_count)
			peak_count = model_count;
		res.count_out = model_count[bsq_pkg::COUNT_FIELD_W-1:0];
		return res;
	endfunction

	task automatic report_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endtask

	// predict on each accepted request word, check each accepted response word
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				expected_rsp.push_back(queue_model_step(req_ch.action, req_ch.priority_req,
					req_ch.message_handle, req_ch.rank));
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsp.size() == 0) begin
					errors++;
					$error("response word with no request outstanding");
				end else begin
					want = expected_rsp.pop_front();
					words_checked++;
					report_field("ok", want.ok, rsp_ch.ok);
					report_field("message_out", want.message_out, rsp_ch.message_out);
					report_field("priority_out", want.priority_out, rsp_ch.priority_out);
					report_field("count_out", want.count_out, rsp_ch.count_out);
				end
			end
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_stalls && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic send_word(input logic [bsq_pkg::ACTION_W-1:0] act,
			input logic [bsq_pkg::PRIO_FIELD_W-1:0] prio,
			input logic [bsq_pkg::HANDLE_FIELD_W-1:0] handle,
			input logic [bsq_pkg::RANK_W-1:0] rank);
		int gap;
		gap = (src_gaps && $urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.action         <= act;
		req_ch.priority_req   <= prio;
		req_ch.message_handle <= handle;
		req_ch.rank           <= rank;
		do @(posedge clk); while (!req_ch.ready);
		words_sent++;
	endtask

	function automatic logic [bsq_pkg::PRIO_FIELD_W-1:0] draw_priority(
			input prio_spread_t spread);
		case (spread)
			SPREAD_NARROW: return bsq_pkg::PRIO_FIELD_W'($urandom_range(0, 3));
			SPREAD_EDGES:  return $urandom_range(0, 1) ? '1 : '0;
			default:       return bsq_pkg::PRIO_FIELD_W'($urandom);
		endcase
	endfunction

	function automatic logic [bsq_pkg::RANK_W-1:0] draw_rank();
		if ($urandom_range(0, 9) < 8)
			return bsq_pkg::RANK_W'($urandom_range(0, model_count + 1));
		return bsq_pkg::RANK_W'($urandom_range(0, 31));
	endfunction

	task automatic test_empty_and_ordering();
		send_word(bsq_pkg::ACT_POP, '0, '0, '0);
		send_word(bsq_pkg::ACT_RANK, '0, '0, 5'd1);
		send_word(bsq_pkg::ACT_RANK, '0, '0, 5'd0);
		send_word(ACT_UNUSED, '0, '0, '0);
		send_word(bsq_pkg::ACT_INSERT, 8'd200, 32'hAAAA_5555, '0);
		send_word(bsq_pkg::ACT_INSERT, 8'hFF, 32'hFFFF_FFFF, '0);
		send_word(bsq_pkg::ACT_INSERT, 8'h00, 32'h0000_0000, '0);
		// equal priority, newest goes ahead
		send_word(bsq_pkg::ACT_INSERT, 8'd200, 32'h5555_AAAA, '0);
		send_word(bsq_pkg::ACT_INSERT, 8'd100, 32'h0000_0001, '0);
		for (int r = 0; r <= 6; r++)
			send_word(bsq_pkg::ACT_RANK, '0, '0, bsq_pkg::RANK_W'(r));
		send_word(bsq_pkg::ACT_RANK, '0, '0, 5'd31);
		send_word(ACT_UNUSED, '1, '1, '1);
		repeat (6) send_word(bsq_pkg::ACT_POP, '0, '0, '0);
	endtask

	task automatic test_fill_and_drain(input prio_spread_t spread);
		repeat (QUEUE_DEPTH + 2)
			send_word(bsq_pkg::ACT_INSERT, draw_priority(spread), $urandom,
				bsq_pkg::RANK_W'($urandom));
		send_word(bsq_pkg::ACT_RANK, '0, '0, bsq_pkg::RANK_W'(QUEUE_DEPTH));
		send_word(bsq_pkg::ACT_RANK, '0, '0, bsq_pkg::RANK_W'(QUEUE_DEPTH + 1));
		send_word(bsq_pkg::ACT_RANK, '0, '0, 5'd31);
		repeat (QUEUE_DEPTH + 1)
			send_word(bsq_pkg::ACT_POP, bsq_pkg::PRIO_FIELD_W'($urandom), $urandom,
				bsq_pkg::RANK_W'($urandom));
	endtask

	// segments lean towards filling, draining or neither
	task automatic test_random_traffic(input int n_words);
		int left;
		int seg_len;
		int insert_pct;
		int pop_pct;
		int pick;
		prio_spread_t spread;
		logic [bsq_pkg::ACTION_W-1:0] act;
		left = n_words;
		while (left > 0) begin
			seg_len = $urandom_range(10, 40);
			case ($urandom_range(0, 2))
				0: begin insert_pct = 65; pop_pct = 15; end
				1: begin insert_pct = 20; pop_pct = 60; end
				default: begin insert_pct = 40; pop_pct = 35; end
			endcase
			spread = prio_spread_t'($urandom_range(0, 2));
			if (idle_allowed) begin
				src_gaps    = $urandom_range(0, 2) != 0;
				sink_stalls = $urandom_range(0, 2) != 0;
			end
			repeat (seg_len) begin
				pick = $urandom_range(0, 99);
				if (pick < 4)
					act = ACT_UNUSED;
				else if (pick < 4 + insert_pct)
					act = bsq_pkg::ACT_INSERT;
				else if (pick < 4 + insert_pct + pop_pct)
					act = bsq_pkg::ACT_POP;
				else
					act = bsq_pkg::ACT_RANK;
				send_word(act, draw_priority(spread), $urandom, draw_rank());
			end
			left -= seg_len;
		end
	endtask

	task automatic test_back_to_back(input int n_words);
		idle_allowed = 1'b0;
		src_gaps     = 1'b0;
		sink_stalls  = 1'b0;
		test_random_traffic(n_words);
	endtask

	initial begin
		req_ch.valid          = 1'b0;
		req_ch.action         = bsq_pkg::ACT_INSERT;
		req_ch.priority_req   = '0;
		req_ch.message_handle = '0;
		req_ch.rank           = '0;
		model_count     = 0;
		errors          = 0;
		words_sent      = 0;
		words_checked   = 0;
		refused_inserts = 0;
		empty_pops      = 0;
		bad_ranks       = 0;
		peak_count      = 0;
		cycle_count     = 0;
		idle_allowed    = 1'b1;
		src_gaps        = 1'b1;
		sink_stalls     = 1'b1;
		arst_n          = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_ordering();
		test_fill_and_drain(SPREAD_WIDE);
		test_fill_and_drain(SPREAD_NARROW);
		test_random_traffic(600);
		test_back_to_back(120);

		req_ch.valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d request words sent, %0d response words checked, peak occupancy %0d",
			words_sent, words_checked, peak_count);
		$display("%0d inserts refused when full, %0d pops on empty, %0d out-of-range ranks",
			refused_inserts, empty_pops, bad_ranks);
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("bounded_sorted_priority_queue verification clean");
		end else begin
			$display("bounded_sorted_priority_queue verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
src/bsq_pkg.sv
src/bsq_if.sv
src/bsq_cell.sv
src/bounded_sorted_priority_queue.sv
src/bsq_checker.sv
tb/sv/bounded_sorted_priority_queue_tb.sv
